// File: rtl/sdrx_pkg.sv
// Shared types, codes and the CRC16 helper for the SD SPI response receiver.
package sdrx_pkg;

    // Default bounds and block sizes
    localparam int R1_POLL_MAX_DEF          = 16;
    localparam int SHORT_TOKEN_POLL_MAX_DEF = 64;
    localparam int BLOCK_TOKEN_POLL_MAX_DEF = 255;
    localparam int SHORT_BLOCK_BYTES_DEF    = 16;
    localparam int BLOCK_BYTES_DEF          = 512;

    // Link bytes
    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] START_TOKEN = 8'hFE;

    // Configuration port
    localparam int          CFG_IDX_W       = 1;
    localparam int          CFG_DATA_W      = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_R1_LIMIT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOKEN_LIMIT = 1'b1;
    localparam logic [7:0]  R1_LIMIT_RST    = 8'd8;
    localparam logic [7:0]  TOKEN_LIMIT_RST = 8'd64;

    // Request kinds
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    typedef enum logic [1:0] {
        MODE_R1    = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_SHORT = 2'd2,
        MODE_BLOCK = 2'd3
    } t_rx_mode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BOUND  = 3'd1,
        ST_IO     = 3'd2,
        ST_RTIME  = 3'd3,
        ST_RINV   = 3'd4,
        ST_TTIME  = 3'd5,
        ST_TINV   = 3'd6,
        ST_CRC    = 3'd7
    } t_status;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_R1     = 7'b0000010,
        PH_WORD   = 7'b0000100,
        PH_TOKEN  = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_CRC_HI = 7'b0100000,
        PH_CRC_LO = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic        data_valid;
        logic [7:0]  data_byte;
        logic        done_res;
        t_status     status;
        logic [7:0]  r1_value;
        logic [31:0] word_value;
        logic [15:0] received_crc;
    } t_result;

    // CRC16-CCITT, poly 0x1021, one byte folded in MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/sdrx_in_if.sv
// Request channel: start items and received link bytes.
interface sdrx_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [1:0] rx_mode;
    logic [7:0] rx_byte;
    logic       read_failed;

    modport source (output valid, output req_type, output rx_mode, output rx_byte,
                    output read_failed, input ready);
    modport sink   (input valid, input req_type, input rx_mode, input rx_byte,
                    input read_failed, output ready);
endinterface

// File: rtl/sdrx_out_if.sv
// Result channel: streamed payload bytes and end-of-transaction status.
interface sdrx_out_if;
    logic        valid;
    logic        ready;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  r1_value;
    logic [31:0] word_value;
    logic [15:0] received_crc;

    modport source (output valid, output data_valid, output data_byte, output done_res,
                    output status, output r1_value, output word_value,
                    output received_crc, input ready);
    modport sink   (input valid, input data_valid, input data_byte, input done_res,
                    input status, input r1_value, input word_value,
                    input received_crc, output ready);
endinterface

// File: rtl/sd_spi_response_receiver_unit.sv
// Top level of the SD card SPI-mode response and data block receiver.
//
// Every accepted item returns exactly one result item, loaded into and held in the
// output register. The unit takes one item per clock: all decoding, the poll
// counters and the bytewise CRC16 update sit between the state registers and
// the output register, so i_in.ready is low only while a result is held in the
// output register and o_out.ready is low. A start item (req_type 0) opens an R1,
// trailing-word, short-block or block transaction; byte items advance it. In the
// block modes each payload byte comes out with data_valid set as it arrives;
// the final result (done_res 1) carries the status, and payload already sent
// must be dropped when that status is not ok. A start while busy drops the
// running transaction. Poll limits are written through the i_cfg port
// (index 0: R1 limit, index 1: token limit) while no item is in flight.
module sd_spi_response_receiver_unit
    import sdrx_pkg::*;
#(
    parameter int R1_POLL_MAX          = R1_POLL_MAX_DEF,
    parameter int SHORT_TOKEN_POLL_MAX = SHORT_TOKEN_POLL_MAX_DEF,
    parameter int BLOCK_TOKEN_POLL_MAX = BLOCK_TOKEN_POLL_MAX_DEF,
    parameter int SHORT_BLOCK_BYTES    = SHORT_BLOCK_BYTES_DEF,
    parameter int BLOCK_BYTES          = BLOCK_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sdrx_in_if.sink               i_in,
    sdrx_out_if.source            o_out
);

    localparam int MAX_BLK = (BLOCK_BYTES > SHORT_BLOCK_BYTES) ? BLOCK_BYTES
                                                               : SHORT_BLOCK_BYTES;
    localparam int CNT_W   = $clog2(MAX_BLK);

    localparam logic [CNT_W-1:0] SHORT_LAST  = CNT_W'(SHORT_BLOCK_BYTES - 1);
    localparam logic [CNT_W-1:0] BLOCK_LAST  = CNT_W'(BLOCK_BYTES - 1);
    localparam logic [CNT_W-1:0] WORD_BYTES  = CNT_W'(4);
    localparam logic [7:0]       R1_BOUND    = 8'(R1_POLL_MAX);
    localparam logic [7:0]       SHORT_BOUND = 8'(SHORT_TOKEN_POLL_MAX);
    localparam logic [7:0]       BLOCK_BOUND = 8'(BLOCK_TOKEN_POLL_MAX);

    // Configuration registers
    logic [7:0] r_r1_limit;
    logic [7:0] r_token_limit;

    // Transaction state
    t_phase          r_phase,   n_phase;
    t_rx_mode        r_mode,    n_mode;
    logic [7:0]      r_poll,    n_poll;
    logic [CNT_W-1:0] r_cnt,    n_cnt;
    logic [15:0]     r_crc,     n_crc;
    logic [31:0]     r_word,    n_word;
    logic [7:0]      r_crc_hi,  n_crc_hi;

    // Output register
    logic    r_out_valid;
    t_result r_res, n_res;

    logic             in_acc;
    logic [7:0]       poll_inc;
    logic [7:0]       tok_bound;
    logic [15:0]      rx_crc;
    logic [CNT_W-1:0] blk_last;
    t_rx_mode         req_mode;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign poll_inc  = r_poll + 8'd1;
    assign rx_crc    = {r_crc_hi, i_in.rx_byte};
    assign blk_last  = (r_mode == MODE_SHORT) ? SHORT_LAST : BLOCK_LAST;
    assign req_mode  = t_rx_mode'(i_in.rx_mode);
    assign tok_bound = (req_mode == MODE_SHORT) ? SHORT_BOUND : BLOCK_BOUND;

    // Decode one item: next state and its result
    always_comb begin
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_poll   = r_poll;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_word   = r_word;
        n_crc_hi = r_crc_hi;

        n_res              = '0;
        n_res.status       = ST_OK;
        n_res.r1_value     = IDLE_BYTE;

        if (i_in.req_type == REQ_START) begin
            n_mode   = req_mode;
            n_poll   = '0;
            n_cnt    = '0;
            n_crc    = '0;
            n_word   = '0;
            n_crc_hi = '0;
            case (req_mode)
                MODE_R1: begin
                    if (r_r1_limit == 8'd0 || r_r1_limit > R1_BOUND) begin
                        n_res.done_res = 1'b1;
                        n_res.status   = ST_BOUND;
                        n_phase        = PH_IDLE;
                    end else begin
                        n_phase = PH_R1;
                    end
                end
                MODE_WORD: begin
                    n_phase = PH_WORD;
                end
                default: begin
                    if (r_token_limit == 8'd0 || r_token_limit > tok_bound) begin
                        n_res.done_res = 1'b1;
                        n_res.status   = ST_BOUND;
                        n_phase        = PH_IDLE;
                    end else begin
                        n_phase = PH_TOKEN;
                    end
                end
            endcase
        end else if (r_phase != PH_IDLE) begin
            if (i_in.read_failed) begin
                // end any active phase on a failed read
                n_res.done_res = 1'b1;
                n_res.status   = ST_IO;
                if (r_phase == PH_WORD) begin
                    n_res.word_value = r_word;
                end
                n_phase = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_R1: begin
                        if (i_in.rx_byte == IDLE_BYTE) begin
                            n_poll = poll_inc;
                            if (poll_inc == 8'd0 || poll_inc >= r_r1_limit) begin
                                n_res.done_res = 1'b1;
                                n_res.status   = ST_RTIME;
                                n_phase        = PH_IDLE;
                            end
                        end else if (i_in.rx_byte[7]) begin
                            n_res.done_res = 1'b1;
                            n_res.status   = ST_RINV;
                            n_phase        = PH_IDLE;
                        end else begin
                            n_res.done_res = 1'b1;
                            n_res.r1_value = i_in.rx_byte;
                            n_phase        = PH_IDLE;
                        end
                    end
                    PH_WORD: begin
                        n_word = {r_word[23:0], i_in.rx_byte};
                        n_cnt  = r_cnt + CNT_W'(1);
                        if (n_cnt >= WORD_BYTES) begin
                            n_res.done_res   = 1'b1;
                            n_res.word_value = n_word;
                            n_phase          = PH_IDLE;
                        end
                    end
                    PH_TOKEN: begin
                        if (i_in.rx_byte == START_TOKEN) begin
                            n_phase = PH_DATA;
                            n_cnt   = '0;
                            n_crc   = '0;
                        end else if (i_in.rx_byte != IDLE_BYTE) begin
                            n_res.done_res = 1'b1;
                            n_res.status   = ST_TINV;
                            n_phase        = PH_IDLE;
                        end else begin
                            n_poll = poll_inc;
                            if (poll_inc == 8'd0 || poll_inc >= r_token_limit) begin
                                n_res.done_res = 1'b1;
                                n_res.status   = ST_TTIME;
                                n_phase        = PH_IDLE;
                            end
                        end
                    end
                    PH_DATA: begin
                        // stream the payload byte and fold it into the CRC
                        n_res.data_valid = 1'b1;
                        n_res.data_byte  = i_in.rx_byte;
                        n_crc            = crc16_byte(r_crc, i_in.rx_byte);
                        if (r_cnt == blk_last) begin
                            n_phase = PH_CRC_HI;
                            n_cnt   = '0;
                        end else begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                    end
                    PH_CRC_HI: begin
                        n_crc_hi = i_in.rx_byte;
                        n_phase  = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        n_res.done_res     = 1'b1;
                        n_res.status       = (rx_crc == r_crc) ? ST_OK : ST_CRC;
                        n_res.received_crc = rx_crc;
                        n_phase            = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1_limit    <= R1_LIMIT_RST;
            r_token_limit <= TOKEN_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_R1_LIMIT:    r_r1_limit    <= i_cfg_data;
                CFG_TOKEN_LIMIT: r_token_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance transaction state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_mode   <= MODE_R1;
            r_poll   <= '0;
            r_cnt    <= '0;
            r_crc    <= '0;
            r_word   <= '0;
            r_crc_hi <= '0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_mode   <= n_mode;
            r_poll   <= n_poll;
            r_cnt    <= n_cnt;
            r_crc    <= n_crc;
            r_word   <= n_word;
            r_crc_hi <= n_crc_hi;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.data_valid   = r_res.data_valid;
    assign o_out.data_byte    = r_res.data_byte;
    assign o_out.done_res     = r_res.done_res;
    assign o_out.status       = r_res.status;
    assign o_out.r1_value     = r_res.r1_value;
    assign o_out.word_value   = r_res.word_value;
    assign o_out.received_crc = r_res.received_crc;

    // A payload byte taken in the data phase comes out as streamed data
    a_data_streams: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.req_type == REQ_BYTE && !i_in.read_failed && r_phase == PH_DATA)
        |=> (r_out_valid && r_res.data_valid && !r_res.done_res))
        else $error("payload byte not streamed");

    // A finishing item leaves the unit idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && n_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("transaction end did not return to idle");

    // A non-final result always reports ok status
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.done_res) |-> (r_res.status == ST_OK))
        else $error("status set on a non-final result");

    // The payload counter stays inside the block
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cnt <= blk_last))
        else $error("payload counter past end of block");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the SD SPI response and data block receiver.
`timescale 1ns / 100ps

module tb_top;
    import sdrx_pkg::*;

    // One link-side request: a transaction start or a received byte
    typedef struct packed {
        logic       req_type;
        t_rx_mode   rx_mode;
        logic [7:0] rx_byte;
        logic       read_failed;
    } t_link_item;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef enum int {
        PACE_OPEN,
        PACE_RANDOM,
        PACE_PERIODIC,
        PACE_LONG
    } t_pace;

    // Directed row: a register write (idx, val) or an item, with typed result if chk
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic                   req;
        t_rx_mode               mode;
        logic [7:0]             val;
        logic                   fail;
        logic                   chk;
        logic                   done;
        t_status                st;
        logic [7:0]             r1;
        logic [31:0]            word;
        logic [15:0]            crc;
    } t_dir_row;

    localparam int ITEM_TARGET = 1700;
    localparam int SWEEP_LEN   = 6;
    // Limit sweep, first entry in the low byte
    localparam logic [8*SWEEP_LEN-1:0] R1_SWEEP  = {8'd8, 8'd255, 8'd17, 8'd0, 8'd16, 8'd1};
    localparam logic [8*SWEEP_LEN-1:0] TOK_SWEEP = {8'd64, 8'd255, 8'd65, 8'd0, 8'd255, 8'd1};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sdrx_in_if  in_ch ();
    sdrx_out_if out_ch ();

    sd_spi_response_receiver_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver state mirror
    t_phase      prd_phase;
    t_rx_mode    cur_mode;
    logic [7:0]  poll_cnt;
    logic [9:0]  byte_cnt;
    logic [15:0] crc_run;
    logic [31:0] word_acc;
    logic [7:0]  crc_hi;
    logic [7:0]  r1_lim;
    logic [7:0]  tok_lim;

    t_result pending[$];
    int      fail_count;
    int      items_sent;
    int      payload_bytes;
    int      status_tally [8];
    int      burst_left;
    int      gap_len;

    // Per-transaction cut points for the random part
    bit      txn_live;
    int      txn_pos;
    int      txn_fail_at;
    int      txn_cut_at;

    t_dir_row dir_tab [29] = '{
        // byte while idle, then a start whose fail bit must be ignored
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'h5A, 1'b0,
          1'b1, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_R1, 8'h00, 1'b1,
          1'b1, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_BLOCK, 8'hFF, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'h00, 1'b0,
          1'b1, 1'b1, ST_OK, 8'h00, 32'h0, 16'h0},
        // response with bit 7 set
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_R1, 8'hFF, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'h80, 1'b0,
          1'b1, 1'b1, ST_RINV, 8'hFF, 32'h0, 16'h0},
        // trailing word, MSB first
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_WORD, 8'h00, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_WORD, 8'hFF, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_WORD, 8'h00, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_WORD, 8'hA5, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_WORD, 8'h5A, 1'b0,
          1'b1, 1'b1, ST_OK, 8'hFF, 32'hFF00A55A, 16'h0},
        // failed read in the word returns the partial word
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_WORD, 8'h00, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_WORD, 8'h12, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_WORD, 8'h34, 1'b1,
          1'b1, 1'b1, ST_IO, 8'hFF, 32'h12, 16'h0},
        // bad start token, and a failed read while polling
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_SHORT, 8'h00, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'h7E, 1'b0,
          1'b1, 1'b1, ST_TINV, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_BLOCK, 8'h00, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'hFF, 1'b1,
          1'b1, 1'b1, ST_IO, 8'hFF, 32'h0, 16'h0},
        // start while busy drops the open block transaction
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_SHORT, 8'h00, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_R1, 8'h00, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'h01, 1'b0,
          1'b1, 1'b1, ST_OK, 8'h01, 32'h0, 16'h0},
        // lower the R1 limit in the middle of a poll
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_R1, 8'h00, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'hFF, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_CFG, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'd2, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'hFF, 1'b0,
          1'b1, 1'b1, ST_RTIME, 8'hFF, 32'h0, 16'h0},
        // poll limits out of bound
        '{ROW_CFG, CFG_TOKEN_LIMIT, REQ_BYTE, MODE_R1, 8'd0, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_SHORT, 8'h00, 1'b0,
          1'b1, 1'b1, ST_BOUND, 8'hFF, 32'h0, 16'h0},
        '{ROW_CFG, CFG_R1_LIMIT, REQ_BYTE, MODE_R1, 8'd17, 1'b0,
          1'b0, 1'b0, ST_OK, 8'hFF, 32'h0, 16'h0},
        '{ROW_ITEM, CFG_R1_LIMIT, REQ_START, MODE_R1, 8'h00, 1'b0,
          1'b1, 1'b1, ST_BOUND, 8'hFF, 32'h0, 16'h0}
    };

    // CRC16-CCITT, one data bit at a time, MSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
        end
        return c;
    endfunction

    // Advance the mirrored state by one item and return the result it must produce
    function automatic t_result receiver_predict(input t_link_item it);
        t_result     res;
        t_status     st;
        logic        fin;
        int          bound;
        int          blk_len;
        logic [15:0] rx_crc;
        res = '0;
        res.r1_value = 8'hFF;
        st = ST_OK;
        fin = 1'b0;
        blk_len = (cur_mode == MODE_SHORT) ? SHORT_BLOCK_BYTES_DEF : BLOCK_BYTES_DEF;
        if (it.req_type == REQ_START) begin
            cur_mode = it.rx_mode;
            poll_cnt = '0;
            byte_cnt = '0;
            crc_run  = '0;
            word_acc = '0;
            crc_hi   = '0;
            case (it.rx_mode)
                MODE_R1: begin
                    if (r1_lim == 8'd0 || r1_lim > R1_POLL_MAX_DEF) begin
                        fin = 1'b1;
                        st  = ST_BOUND;
                    end else begin
                        prd_phase = PH_R1;
                    end
                end
                MODE_WORD: begin
                    prd_phase = PH_WORD;
                end
                default: begin
                    bound = (it.rx_mode == MODE_SHORT) ? SHORT_TOKEN_POLL_MAX_DEF
                                                       : BLOCK_TOKEN_POLL_MAX_DEF;
                    if (tok_lim == 8'd0 || tok_lim > bound) begin
                        fin = 1'b1;
                        st  = ST_BOUND;
                    end else begin
                        prd_phase = PH_TOKEN;
                    end
                end
            endcase
        end else if (prd_phase != PH_IDLE) begin
            if (it.read_failed) begin
                fin = 1'b1;
                st  = ST_IO;
                if (prd_phase == PH_WORD) res.word_value = word_acc;
            end else begin
                case (prd_phase)
                    PH_R1: begin
                        if (it.rx_byte == IDLE_BYTE) begin
                            poll_cnt = poll_cnt + 8'd1;
                            if (poll_cnt == 8'd0 || poll_cnt >= r1_lim) begin
                                fin = 1'b1;
                                st  = ST_RTIME;
                            end
                        end else if (it.rx_byte[7]) begin
                            fin = 1'b1;
                            st  = ST_RINV;
                        end else begin
                            fin = 1'b1;
                            res.r1_value = it.rx_byte;
                        end
                    end
                    PH_WORD: begin
                        word_acc = {word_acc[23:0], it.rx_byte};
                        byte_cnt = byte_cnt + 10'd1;
                        if (byte_cnt >= 10'd4) begin
                            fin = 1'b1;
                            res.word_value = word_acc;
                        end
                    end
                    PH_TOKEN: begin
                        if (it.rx_byte == START_TOKEN) begin
                            prd_phase = PH_DATA;
                            byte_cnt  = '0;
                            crc_run   = '0;
                        end else if (it.rx_byte != IDLE_BYTE) begin
                            fin = 1'b1;
                            st  = ST_TINV;
                        end else begin
                            poll_cnt = poll_cnt + 8'd1;
                            if (poll_cnt == 8'd0 || poll_cnt >= tok_lim) begin
                                fin = 1'b1;
                                st  = ST_TTIME;
                            end
                        end
                    end
                    PH_DATA: begin
                        res.data_valid = 1'b1;
                        res.data_byte  = it.rx_byte;
                        crc_run = crc_fold(crc_run, it.rx_byte);
                        if (byte_cnt + 1 >= blk_len) begin
                            prd_phase = PH_CRC_HI;
                            byte_cnt  = '0;
                        end else begin
                            byte_cnt = byte_cnt + 10'd1;
                        end
                    end
                    PH_CRC_HI: begin
                        crc_hi = it.rx_byte;
                        prd_phase = PH_CRC_LO;
                    end
                    default: begin
                        rx_crc = {crc_hi, it.rx_byte};
                        fin = 1'b1;
                        st  = (rx_crc == crc_run) ? ST_OK : ST_CRC;
                        res.received_crc = rx_crc;
                    end
                endcase
            end
        end
        if (fin) begin
            res.done_res = 1'b1;
            res.status   = st;
            prd_phase    = PH_IDLE;
        end
        return res;
    endfunction

    // Present one item in the current burst, wait for it to be taken, log its result
    task automatic send_item(input t_link_item it, input bit typed, input t_result typed_res);
        t_result guess;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 16);
            gap_len = $urandom_range(0, 6);
            if (gap_len != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= it.req_type;
        in_ch.rx_mode     <= it.rx_mode;
        in_ch.rx_byte     <= it.rx_byte;
        in_ch.read_failed <= it.read_failed;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (!(it.req_type == REQ_BYTE && prd_phase == PH_IDLE)) items_sent++;
        guess = receiver_predict(it);
        pending.push_back(typed ? typed_res : guess);
    endtask

    // Hold the sender until every result is back
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        wait_quiet();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_R1_LIMIT) r1_lim = val;
        else tok_lim = val;
    endtask

    // Mostly in range, sometimes zero or above the bound
    function automatic logic [7:0] pick_limit(input int cap);
        case ($urandom_range(0, 9))
            0: begin
                return 8'd0;
            end
            1: begin
                return (cap < 255) ? 8'($urandom_range(cap + 1, 255)) : 8'd255;
            end
            default: begin
                return 8'($urandom_range(1, cap));
            end
        endcase
    endfunction

    // Send one byte of the running transaction unless it was ended or cut
    task automatic link_byte(input logic [7:0] b);
        t_link_item it;
        if (!txn_live) return;
        if (txn_pos == txn_cut_at) begin
            txn_live = 1'b0;
            return;
        end
        it.req_type    = REQ_BYTE;
        it.rx_mode     = t_rx_mode'($urandom_range(0, 3));
        it.rx_byte     = b;
        it.read_failed = (txn_pos == txn_fail_at);
        send_item(it, 1'b0, '0);
        txn_pos++;
        if (prd_phase == PH_IDLE) txn_live = 1'b0;
    endtask

    // One random transaction: mostly well formed, with noise, failures and cuts
    task automatic run_transaction(input int txn_no);
        t_link_item  it;
        t_rx_mode    md;
        int          pick;
        int          len;
        int          polls;
        int          lim;
        logic [7:0]  b;
        logic [15:0] crc;
        pick = $urandom_range(0, 99);
        if (txn_no == 3 || txn_no == 20 || pick < 2) md = MODE_BLOCK;
        else if (pick < 32) md = MODE_R1;
        else if (pick < 52) md = MODE_WORD;
        else md = MODE_SHORT;
        len = (md == MODE_BLOCK) ? BLOCK_BYTES_DEF : SHORT_BLOCK_BYTES_DEF;

        // stray bytes between transactions
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                it.req_type    = REQ_BYTE;
                it.rx_mode     = t_rx_mode'($urandom_range(0, 3));
                it.rx_byte     = 8'($urandom_range(0, 255));
                it.read_failed = 1'($urandom_range(0, 1));
                send_item(it, 1'b0, '0);
            end
        end

        txn_live    = 1'b1;
        txn_pos     = 0;
        txn_fail_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 3) : -1;
        txn_cut_at  = ($urandom_range(0, 14) == 0) ? $urandom_range(0, len + 3) : -1;
        it.req_type    = REQ_START;
        it.rx_mode     = md;
        it.rx_byte     = 8'($urandom_range(0, 255));
        it.read_failed = 1'($urandom_range(0, 1));
        send_item(it, 1'b0, '0);
        if (prd_phase == PH_IDLE) return;

        lim   = (md == MODE_R1) ? r1_lim : tok_lim;
        polls = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, lim + 1);
        case (md)
            MODE_R1: begin
                repeat (polls) link_byte(IDLE_BYTE);
                if ($urandom_range(0, 4) == 0) link_byte(8'($urandom_range(8'h80, 8'hFE)));
                else link_byte(8'($urandom_range(0, 8'h7F)));
            end
            MODE_WORD: begin
                repeat (4) link_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                repeat (polls) link_byte(IDLE_BYTE);
                if ($urandom_range(0, 9) == 0) link_byte(8'($urandom_range(0, 8'hFD)));
                else link_byte(START_TOKEN);
                crc = '0;
                for (int n = 0; n < len; n++) begin
                    case ($urandom_range(0, 9))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    crc = crc_fold(crc, b);
                    link_byte(b);
                end
                // corrupt one bit of the CRC now and then
                if ($urandom_range(0, 4) == 0) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
                link_byte(crc[15:8]);
                link_byte(crc[7:0]);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare every taken result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending.size() == 0) begin
                $display("%0t ns: result with none expected, got status %0d done %0b",
                         $time, out_ch.status, out_ch.done_res);
                fail_count++;
            end else begin
                want = pending.pop_front();
                check_field("data_valid", want.data_valid, out_ch.data_valid);
                check_field("data_byte", want.data_byte, out_ch.data_byte);
                check_field("done_res", want.done_res, out_ch.done_res);
                check_field("status", want.status, out_ch.status);
                check_field("r1_value", want.r1_value, out_ch.r1_value);
                check_field("word_value", want.word_value, out_ch.word_value);
                check_field("received_crc", want.received_crc, out_ch.received_crc);
                if (want.done_res) status_tally[want.status]++;
                if (want.data_valid) payload_bytes++;
            end
        end
    end

    // Result-side stalls, switching at random between pacing styles
    initial begin : sink_pacing
        t_pace style;
        int    span;
        int    hold;
        out_ch.ready <= 1'b0;
        style = PACE_OPEN;
        span  = 0;
        hold  = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                style = t_pace'($urandom_range(0, 3));
                span  = $urandom_range(50, 300);
            end
            span--;
            case (style)
                PACE_OPEN: begin
                    out_ch.ready <= 1'b1;
                end
                PACE_RANDOM: begin
                    out_ch.ready <= ($urandom_range(0, 3) != 0);
                end
                PACE_PERIODIC: begin
                    out_ch.ready <= (span % 5 != 1);
                end
                default: begin
                    if (hold > 0) begin
                        hold--;
                        out_ch.ready <= 1'b0;
                    end else if ($urandom_range(0, 5) == 0) begin
                        hold = $urandom_range(1, 12);
                        out_ch.ready <= 1'b0;
                    end else begin
                        out_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("Timeout with %0d results still expected", pending.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        t_link_item it;
        t_result    typed_res;
        int         txn_no;
        int         sweep_idx;
        int         tok_cap;

        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_idx           <= CFG_R1_LIMIT;
        cfg_data          <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.req_type    <= REQ_START;
        in_ch.rx_mode     <= MODE_R1;
        in_ch.rx_byte     <= '0;
        in_ch.read_failed <= 1'b0;
        prd_phase  = PH_IDLE;
        cur_mode   = MODE_R1;
        poll_cnt   = '0;
        byte_cnt   = '0;
        crc_run    = '0;
        word_acc   = '0;
        crc_hi     = '0;
        r1_lim     = R1_LIMIT_RST;
        tok_lim    = TOKEN_LIMIT_RST;
        fail_count = 0;
        items_sent = 0;
        payload_bytes = 0;
        burst_left = 0;
        gap_len    = 0;
        txn_live   = 1'b0;
        foreach (status_tally[s]) status_tally[s] = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_tab[n]) begin
            if (dir_tab[n].kind == ROW_CFG) begin
                set_limit(dir_tab[n].idx, dir_tab[n].val);
            end else begin
                it.req_type    = dir_tab[n].req;
                it.rx_mode     = dir_tab[n].mode;
                it.rx_byte     = dir_tab[n].val;
                it.read_failed = dir_tab[n].fail;
                typed_res = '0;
                typed_res.done_res     = dir_tab[n].done;
                typed_res.status       = dir_tab[n].st;
                typed_res.r1_value     = dir_tab[n].r1;
                typed_res.word_value   = dir_tab[n].word;
                typed_res.received_crc = dir_tab[n].crc;
                send_item(it, dir_tab[n].chk, typed_res);
            end
        end

        // random transactions, limits swept first through the extremes
        txn_no    = 0;
        sweep_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (txn_no % 6 == 0) begin
                if (sweep_idx < SWEEP_LEN) begin
                    set_limit(CFG_R1_LIMIT, R1_SWEEP[8*sweep_idx +: 8]);
                    set_limit(CFG_TOKEN_LIMIT, TOK_SWEEP[8*sweep_idx +: 8]);
                    sweep_idx++;
                end else begin
                    tok_cap = ($urandom_range(0, 1) == 0) ? SHORT_TOKEN_POLL_MAX_DEF
                                                          : BLOCK_TOKEN_POLL_MAX_DEF;
                    set_limit(CFG_R1_LIMIT, pick_limit(R1_POLL_MAX_DEF));
                    set_limit(CFG_TOKEN_LIMIT, pick_limit(tok_cap));
                end
            end
            run_transaction(txn_no);
            txn_no++;
        end

        wait_quiet();
        repeat (4) @(posedge i_clk);

        $display("Covered %0d link items over %0d random transactions, %0d payload bytes out",
                 items_sent, txn_no, payload_bytes);
        $display("Ends per status, ok to crc_bad: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4], status_tally[5], status_tally[6], status_tally[7]);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
